FILE: rtl/core/ps2_host_link_frame_engine_defines.svh
// assertion helpers for the ps2 host link frame engine
`ifndef PS2_HOST_LINK_FRAME_ENGINE_DEFINES_SVH
`define PS2_HOST_LINK_FRAME_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PS2_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define PS2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PS2_ASSERT_SAME(label, ante, cons, msg)
`define PS2_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ps2hl_pkg.sv
package ps2hl_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int CFG_WIDTH   = 16;
    localparam int BYTE_WIDTH  = 8;
    localparam int INDEX_WIDTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE           = 2'd0,
        MODE_RECEPTION      = 2'd1,
        MODE_RETRANSMISSION = 2'd2,
        MODE_RTS            = 2'd3
    } link_mode_t;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_SEND = 1'b1;

    localparam logic CFG_GLITCH_MIN = 1'b0;
    localparam logic CFG_FRAME_GAP  = 1'b1;

    localparam logic [CFG_WIDTH-1:0] GLITCH_MIN_RESET = 16'd60;
    localparam logic [CFG_WIDTH-1:0] FRAME_GAP_RESET  = 16'd200;

    localparam logic [INDEX_WIDTH-1:0] RX_IDX_START    = 4'd0;
    localparam logic [INDEX_WIDTH-1:0] RX_IDX_LAST_BIT = 4'd8;
    localparam logic [INDEX_WIDTH-1:0] RX_IDX_PARITY   = 4'd9;
    localparam logic [INDEX_WIDTH-1:0] RX_IDX_STOP     = 4'd10;

    localparam logic [INDEX_WIDTH-1:0] TX_IDX_FIRST    = 4'd1;
    localparam logic [INDEX_WIDTH-1:0] TX_IDX_LAST_BIT = 4'd8;
    localparam logic [INDEX_WIDTH-1:0] TX_IDX_PARITY   = 4'd9;
    localparam logic [INDEX_WIDTH-1:0] TX_IDX_STOP     = 4'd10;
    localparam logic [INDEX_WIDTH-1:0] TX_IDX_ACK      = 4'd11;

endpackage

FILE: rtl/core/ps2_host_link_frame_engine.sv
// channel   | direction | handshake          | payload
// s_        | in        | s_valid / s_ready  | operation, time_us, data_level, send_byte
// m_        | out       | m_valid / m_ready  | line controls, rx byte and flags, tx_done
// cfg_      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (ready out of reset)
//
// one word per cycle sustained while the result register is not stalled; an s_ accept reaches m_valid
// through the input register, then one pass of edge/send logic into the result register
// the link state updates when a word leaves the input register for the result register
// a stalled result register stops the input register; s_ready then drops
// aresetn is synchronous, active low; all link state returns to idle
`include "ps2_host_link_frame_engine_defines.svh"

module ps2_host_link_frame_engine
    import ps2hl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [TIME_WIDTH-1:0] s_time_us,
    input  logic                  s_data_level,
    input  logic [BYTE_WIDTH-1:0] s_send_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_data_drive,
    output logic                  m_data_out,
    output logic                  m_clock_hold_low,
    output logic                  m_rx_valid,
    output logic [BYTE_WIDTH-1:0] m_rx_byte,
    output logic                  m_resend_needed,
    output logic                  m_tx_done,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data
);

    // configuration
    logic [CFG_WIDTH-1:0] glitch_min_reg;
    logic [CFG_WIDTH-1:0] frame_gap_reg;

    // input register
    logic                  in_valid_reg;
    logic                  in_op_reg;
    logic [TIME_WIDTH-1:0] in_time_reg;
    logic                  in_level_reg;
    logic [BYTE_WIDTH-1:0] in_byte_reg;

    // link state
    link_mode_t             mode_reg, mode_next;
    logic [INDEX_WIDTH-1:0] tx_idx_reg, tx_idx_next;
    logic [INDEX_WIDTH-1:0] rx_idx_reg, rx_idx_next;
    logic [BYTE_WIDTH-1:0]  rx_shift_reg, rx_shift_next;
    logic                   rx_acc_reg, rx_acc_next;
    logic                   rx_seen_reg, rx_seen_next;
    logic [BYTE_WIDTH-1:0]  tx_shift_reg, tx_shift_next;
    logic                   tx_parity_reg, tx_parity_next;
    logic [TIME_WIDTH-1:0]  last_edge_reg, last_edge_next;
    logic                   drive_reg, drive_next;
    logic                   level_reg, level_next;
    logic                   clklow_reg, clklow_next;

    // per-word flags
    logic                  rx_valid_next;
    logic [BYTE_WIDTH-1:0] rx_byte_next;
    logic                  resend_next;
    logic                  done_next;

    // result register
    logic                  out_valid_reg;
    logic                  out_drive_reg;
    logic                  out_data_reg;
    logic                  out_clklow_reg;
    logic                  out_rx_valid_reg;
    logic [BYTE_WIDTH-1:0] out_rx_byte_reg;
    logic                  out_resend_reg;
    logic                  out_done_reg;

    logic                  advance;
    logic [TIME_WIDTH-1:0] diff;
    logic                  glitch_ok;
    logic                  gap_over;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = aresetn && (!in_valid_reg || advance);
    assign cfg_ready = aresetn;

    assign diff      = in_time_reg - last_edge_reg;
    assign glitch_ok = diff >= TIME_WIDTH'(glitch_min_reg);
    assign gap_over  = diff > TIME_WIDTH'(frame_gap_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glitch_min_reg <= GLITCH_MIN_RESET;
            frame_gap_reg  <= FRAME_GAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GLITCH_MIN: glitch_min_reg <= cfg_data;
                CFG_FRAME_GAP:  frame_gap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_operation;
            in_time_reg  <= s_time_us;
            in_level_reg <= s_data_level;
            in_byte_reg  <= s_send_byte;
        end
    end

    always_comb begin
        mode_next      = mode_reg;
        tx_idx_next    = tx_idx_reg;
        rx_idx_next    = rx_idx_reg;
        rx_shift_next  = rx_shift_reg;
        rx_acc_next    = rx_acc_reg;
        rx_seen_next   = rx_seen_reg;
        tx_shift_next  = tx_shift_reg;
        tx_parity_next = tx_parity_reg;
        last_edge_next = last_edge_reg;
        drive_next     = drive_reg;
        level_next     = level_reg;
        clklow_next    = clklow_reg;
        rx_valid_next  = 1'b0;
        rx_byte_next   = '0;
        resend_next    = 1'b0;
        done_next      = 1'b0;

        if (in_op_reg == OP_SEND) begin
            tx_shift_next  = in_byte_reg;
            tx_parity_next = ~^in_byte_reg;
            tx_idx_next    = TX_IDX_FIRST;
            mode_next      = MODE_RTS;
            drive_next     = 1'b1;
            level_next     = 1'b0;
            clklow_next    = 1'b0;
        end else if (mode_reg == MODE_RTS) begin
            if (glitch_ok) begin
                last_edge_next = in_time_reg;
                if (tx_idx_reg >= TX_IDX_FIRST && tx_idx_reg <= TX_IDX_LAST_BIT) begin
                    drive_next  = 1'b1;
                    level_next  = tx_shift_reg[3'(tx_idx_reg - TX_IDX_FIRST)];
                    tx_idx_next = tx_idx_reg + 4'd1;
                end else if (tx_idx_reg == TX_IDX_PARITY) begin
                    drive_next  = 1'b1;
                    level_next  = tx_parity_reg;
                    tx_idx_next = TX_IDX_STOP;
                end else if (tx_idx_reg == TX_IDX_STOP) begin
                    drive_next  = 1'b0;
                    level_next  = 1'b0;
                    tx_idx_next = TX_IDX_ACK;
                end else begin
                    // ack edge completes; any other index abandons the send
                    drive_next  = 1'b0;
                    level_next  = 1'b0;
                    mode_next   = MODE_IDLE;
                    tx_idx_next = TX_IDX_FIRST;
                    done_next   = (tx_idx_reg == TX_IDX_ACK);
                end
            end
        end else begin
            // frame gap takes precedence over the glitch filter
            if (gap_over) begin
                mode_next     = MODE_RECEPTION;
                rx_idx_next   = RX_IDX_START;
                rx_shift_next = '0;
                rx_acc_next   = 1'b1;
            end
            if (gap_over || glitch_ok) begin
                last_edge_next = in_time_reg;
                if (rx_idx_next == RX_IDX_START) begin
                    rx_idx_next = 4'd1;
                end else if (rx_idx_next <= RX_IDX_LAST_BIT) begin
                    if (in_level_reg) begin
                        rx_shift_next = rx_shift_next
                                      | (8'd1 << 3'(rx_idx_next - 4'd1));
                        rx_acc_next   = ~rx_acc_next;
                    end
                    rx_idx_next = rx_idx_next + 4'd1;
                end else if (rx_idx_next == RX_IDX_PARITY) begin
                    rx_seen_next = in_level_reg;
                    rx_idx_next  = RX_IDX_STOP;
                end else begin
                    if (rx_idx_next == RX_IDX_STOP) begin
                        if (rx_seen_reg != rx_acc_next) begin
                            clklow_next = 1'b1;
                            mode_next   = MODE_RETRANSMISSION;
                            resend_next = 1'b1;
                        end else begin
                            rx_valid_next = 1'b1;
                            rx_byte_next  = rx_shift_next;
                            mode_next     = MODE_IDLE;
                        end
                    end
                    rx_idx_next   = RX_IDX_START;
                    rx_shift_next = '0;
                    rx_acc_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            tx_idx_reg    <= TX_IDX_FIRST;
            rx_idx_reg    <= RX_IDX_START;
            rx_shift_reg  <= '0;
            rx_acc_reg    <= 1'b1;
            rx_seen_reg   <= 1'b1;
            tx_shift_reg  <= '0;
            tx_parity_reg <= 1'b0;
            last_edge_reg <= '0;
            drive_reg     <= 1'b0;
            level_reg     <= 1'b0;
            clklow_reg    <= 1'b0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            tx_idx_reg    <= tx_idx_next;
            rx_idx_reg    <= rx_idx_next;
            rx_shift_reg  <= rx_shift_next;
            rx_acc_reg    <= rx_acc_next;
            rx_seen_reg   <= rx_seen_next;
            tx_shift_reg  <= tx_shift_next;
            tx_parity_reg <= tx_parity_next;
            last_edge_reg <= last_edge_next;
            drive_reg     <= drive_next;
            level_reg     <= level_next;
            clklow_reg    <= clklow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg    <= drive_next;
            out_data_reg     <= drive_next && level_next;
            out_clklow_reg   <= clklow_next;
            out_rx_valid_reg <= rx_valid_next;
            out_rx_byte_reg  <= rx_byte_next;
            out_resend_reg   <= resend_next;
            out_done_reg     <= done_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_data_drive     = out_drive_reg;
    assign m_data_out       = out_data_reg;
    assign m_clock_hold_low = out_clklow_reg;
    assign m_rx_valid       = out_rx_valid_reg;
    assign m_rx_byte        = out_rx_byte_reg;
    assign m_resend_needed  = out_resend_reg;
    assign m_tx_done        = out_done_reg;

    `PS2_ASSERT_SAME(a_drive_only_in_rts, mode_reg != MODE_RTS, !drive_reg, "data driven outside a send")
    `PS2_ASSERT_SAME(a_level_needs_drive, m_valid && m_data_out, m_data_drive, "data level without drive")
    `PS2_ASSERT_SAME(a_done_released, m_valid && m_tx_done, !m_data_drive && !m_rx_valid, "tx_done with line still driven")
    `PS2_ASSERT_SAME(a_rx_excl, m_valid && m_rx_valid, !m_resend_needed, "byte and parity error together")
    `PS2_ASSERT_NEXT(a_stall_blocks_input, in_valid_reg && out_valid_reg && !m_ready, in_valid_reg && out_valid_reg, "word lost under stall")

endmodule

FILE: bench/tb_ps2_host_link_frame_engine.sv
module tb_ps2_host_link_frame_engine;
    import ps2hl_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       data_drive;
        logic       data_out;
        logic       clock_hold_low;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       resend_needed;
        logic       tx_done;
    } line_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic [TIME_WIDTH-1:0] s_time_us;
    logic                  s_data_level;
    logic [BYTE_WIDTH-1:0] s_send_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_data_drive;
    logic                  m_data_out;
    logic                  m_clock_hold_low;
    logic                  m_rx_valid;
    logic [BYTE_WIDTH-1:0] m_rx_byte;
    logic                  m_resend_needed;
    logic                  m_tx_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_WIDTH-1:0]  cfg_data;

    // host link state as the bench sees it
    link_mode_t            link_mode;
    logic [INDEX_WIDTH-1:0] tx_bit_idx;
    logic [INDEX_WIDTH-1:0] rx_bit_idx;
    logic [7:0]            rx_shift;
    logic [7:0]            tx_shift;
    logic                  rx_parity;
    logic                  rx_parity_seen;
    logic                  tx_parity;
    logic [TIME_WIDTH-1:0] last_edge_us;
    logic                  line_drive;
    logic                  line_level;
    logic                  line_clk_low;
    logic [CFG_WIDTH-1:0]  glitch_min_us;
    logic [CFG_WIDTH-1:0]  frame_gap_us;

    line_word_t expected_line_q[$];
    int errors = 0;
    int words_sent = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    ps2_host_link_frame_engine dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_time_us        (s_time_us),
        .s_data_level     (s_data_level),
        .s_send_byte      (s_send_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_drive     (m_data_drive),
        .m_data_out       (m_data_out),
        .m_clock_hold_low (m_clock_hold_low),
        .m_rx_valid       (m_rx_valid),
        .m_rx_byte        (m_rx_byte),
        .m_resend_needed  (m_resend_needed),
        .m_tx_done        (m_tx_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_rx_frame();
        rx_bit_idx = RX_IDX_START;
        rx_shift   = 8'h00;
        rx_parity  = 1'b1;
    endfunction

    function automatic void reset_link_state();
        glitch_min_us  = GLITCH_MIN_RESET;
        frame_gap_us   = FRAME_GAP_RESET;
        link_mode      = MODE_IDLE;
        tx_bit_idx     = TX_IDX_FIRST;
        clear_rx_frame();
        rx_parity_seen = 1'b1;
        tx_shift       = 8'h00;
        tx_parity      = 1'b0;
        last_edge_us   = '0;
        line_drive     = 1'b0;
        line_level     = 1'b0;
        line_clk_low   = 1'b0;
    endfunction

    function automatic line_word_t step_link_model(input logic op, input logic [31:0] t,
                                                   input logic lvl, input logic [7:0] b);
        line_word_t r;
        logic [31:0] diff;
        logic        accept;
        r = '0;
        diff = t - last_edge_us;
        if (op == OP_SEND) begin
            tx_shift     = b;
            tx_parity    = ~^b;
            tx_bit_idx   = TX_IDX_FIRST;
            link_mode    = MODE_RTS;
            line_drive   = 1'b1;
            line_level   = 1'b0;
            line_clk_low = 1'b0;
        end else if (link_mode == MODE_RTS) begin
            // while sending only the glitch filter applies
            if (diff >= glitch_min_us) begin
                last_edge_us = t;
                if (tx_bit_idx >= TX_IDX_FIRST && tx_bit_idx <= TX_IDX_LAST_BIT) begin
                    line_drive = 1'b1;
                    line_level = tx_shift[tx_bit_idx - TX_IDX_FIRST];
                    tx_bit_idx = tx_bit_idx + 1'b1;
                end else if (tx_bit_idx == TX_IDX_PARITY) begin
                    line_drive = 1'b1;
                    line_level = tx_parity;
                    tx_bit_idx = TX_IDX_STOP;
                end else if (tx_bit_idx == TX_IDX_STOP) begin
                    line_drive = 1'b0;
                    line_level = 1'b0;
                    tx_bit_idx = TX_IDX_ACK;
                end else begin
                    r.tx_done  = (tx_bit_idx == TX_IDX_ACK);
                    line_drive = 1'b0;
                    line_level = 1'b0;
                    link_mode  = MODE_IDLE;
                    tx_bit_idx = TX_IDX_FIRST;
                end
            end
        end else begin
            // frame gap wins over the glitch filter
            accept = 1'b1;
            if (diff > frame_gap_us) begin
                link_mode = MODE_RECEPTION;
                clear_rx_frame();
            end else if (diff < glitch_min_us) begin
                accept = 1'b0;
            end
            if (accept) begin
                last_edge_us = t;
                if (rx_bit_idx == RX_IDX_START) begin
                    rx_bit_idx = RX_IDX_START + 1'b1;
                end else if (rx_bit_idx <= RX_IDX_LAST_BIT) begin
                    if (lvl) begin
                        rx_shift[rx_bit_idx - 1'b1] = 1'b1;
                        rx_parity = ~rx_parity;
                    end
                    rx_bit_idx = rx_bit_idx + 1'b1;
                end else if (rx_bit_idx == RX_IDX_PARITY) begin
                    rx_parity_seen = lvl;
                    rx_bit_idx = RX_IDX_STOP;
                end else begin
                    if (rx_bit_idx == RX_IDX_STOP) begin
                        if (rx_parity_seen != rx_parity) begin
                            line_clk_low    = 1'b1;
                            link_mode       = MODE_RETRANSMISSION;
                            r.resend_needed = 1'b1;
                        end else begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = rx_shift;
                            link_mode  = MODE_IDLE;
                        end
                    end
                    clear_rx_frame();
                end
            end
        end
        r.data_drive     = line_drive;
        r.data_out       = line_drive & line_level;
        r.clock_hold_low = line_clk_low;
        return r;
    endfunction

    // receiver: random stalls, or a counted hold-off when the test asks for one
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        line_word_t got;
        line_word_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_data_drive, m_data_out, m_clock_hold_low, m_rx_valid, m_rx_byte,
                    m_resend_needed, m_tx_done};
            if (expected_line_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none got %h", $time, got);
            end else begin
                want = expected_line_q.pop_front();
                check_field("data_drive", want.data_drive, got.data_drive);
                check_field("data_out", want.data_out, got.data_out);
                check_field("clock_hold_low", want.clock_hold_low, got.clock_hold_low);
                check_field("rx_valid", want.rx_valid, got.rx_valid);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("resend_needed", want.resend_needed, got.resend_needed);
                check_field("tx_done", want.tx_done, got.tx_done);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_ps2_host_link_frame_engine: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic op, input logic [31:0] t, input logic lvl,
                             input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_time_us    <= t;
        s_data_level <= lvl;
        s_send_byte  <= b;
        do @(posedge aclk); while (!s_ready);
        expected_line_q.push_back(step_link_model(op, t, lvl, b));
        words_sent++;
    endtask

    task automatic edge_after(input logic [31:0] delta, input logic lvl);
        send_word(OP_EDGE, last_edge_us + delta, lvl, 8'($urandom));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_line_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_WIDTH-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_GLITCH_MIN)
            glitch_min_us = val;
        else
            frame_gap_us = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rx_step();
        if (glitch_min_us <= frame_gap_us)
            return $urandom_range(frame_gap_us, glitch_min_us);
        return glitch_min_us;
    endfunction

    function automatic logic [31:0] tx_step();
        if ($urandom_range(15) == 0)
            return $urandom | 32'h0001_0000;
        return glitch_min_us + $urandom_range(40);
    endfunction

    // edge closer than the glitch interval, and outside a send within the frame gap too
    task automatic glitch_edge();
        logic [31:0] lim;
        lim = glitch_min_us - 1;
        if (link_mode != MODE_RTS && lim > frame_gap_us)
            lim = frame_gap_us;
        edge_after($urandom_range(lim), 1'($urandom_range(1)));
    endtask

    task automatic device_frame(input logic [7:0] b, input logic good, input int n_edges);
        logic [10:0] levels;
        logic        start_lvl;
        logic        stop_lvl;
        start_lvl = $urandom_range(1);
        stop_lvl  = $urandom_range(1);
        levels = {stop_lvl, good ? ~^b : ^b, b, start_lvl};
        for (int i = 0; i < n_edges; i++) begin
            if (i == 0) begin
                if ($urandom_range(3) == 0)
                    edge_after($urandom, levels[0]);
                else
                    edge_after(frame_gap_us + 1 + $urandom_range(30), levels[0]);
            end else begin
                if (glitch_min_us != 0 && $urandom_range(11) == 0)
                    glitch_edge();
                edge_after(rx_step(), levels[i]);
            end
        end
    endtask

    task automatic host_send(input logic [7:0] b, input int n_edges);
        send_word(OP_SEND, $urandom, 1'($urandom_range(1)), b);
        for (int i = 0; i < n_edges; i++) begin
            if (glitch_min_us != 0 && $urandom_range(9) == 0)
                glitch_edge();
            edge_after(tx_step(), 1'($urandom_range(1)));
        end
    endtask

    task automatic line_noise();
        int n;
        n = $urandom_range(6, 1);
        repeat (n) begin
            if ($urandom_range(5) == 0)
                send_word(OP_SEND, $urandom, 1'($urandom_range(1)), 8'($urandom));
            else if ($urandom_range(3) == 0)
                edge_after($urandom, 1'($urandom_range(1)));
            else
                edge_after($urandom_range(frame_gap_us + 2), 1'($urandom_range(1)));
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                device_frame(8'($urandom), 1'b1, 11);
            end else if (pick < 55) begin
                device_frame(8'($urandom), 1'b0, 11);
                if ($urandom_range(1))
                    host_send(8'hFE, 11);
            end else if (pick < 75) begin
                host_send(8'($urandom), 11);
            end else if (pick < 82) begin
                // frame cut short, whatever follows lands mid-reception
                device_frame(8'($urandom), 1'($urandom_range(1)), $urandom_range(10, 1));
            end else if (pick < 88) begin
                host_send(8'($urandom), $urandom_range(10));
            end else begin
                line_noise();
            end
        end
    endtask

    task automatic test_directed();
        // bad parity on 0xff straddling the timestamp wrap, with a glitch mid-frame
        send_word(OP_EDGE, 32'hFFFF_FF38, 1'b0, 8'h00);
        for (int i = 1; i <= 8; i++) begin
            edge_after(32'd60, 1'b1);
            if (i == 3)
                edge_after(32'd59, 1'b0);
        end
        edge_after(32'd200, 1'b0);
        edge_after(32'd200, 1'b1);
        // resend: hold released, glitch ignored, long gap does not restart a send
        send_word(OP_SEND, 32'h0000_0000, 1'b1, 8'hFE);
        edge_after(32'd1, 1'b0);
        edge_after(32'd60, 1'b1);
        edge_after(32'hFFFF_0000, 1'b0);
        for (int i = 0; i < 9; i++)
            edge_after(32'd60, 1'($urandom_range(1)));
    endtask

    task automatic test_config_sweep();
        logic [CFG_WIDTH-1:0] glitch_set [6];
        logic [CFG_WIDTH-1:0] gap_set [6];
        int idle_set [4];
        int stall_set [4];
        glitch_set = '{16'd0, 16'd65535, 16'd1, 16'd65535, 16'd25, 16'd60};
        gap_set    = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd90, 16'd200};
        idle_set   = '{0, 83, 0, 29};
        stall_set  = '{0, 0, 83, 29};
        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(CFG_GLITCH_MIN, glitch_set[p]);
            write_reg(CFG_FRAME_GAP, gap_set[p]);
            send_idle_pct  = idle_set[p % 4];
            recv_stall_pct = stall_set[p % 4];
            random_traffic(120);
        end
    endtask

    task automatic test_backpressure();
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        random_traffic(80);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        random_traffic(40);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_EDGE;
        s_time_us    = '0;
        s_data_level = 1'b0;
        s_send_byte  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_GLITCH_MIN;
        cfg_data     = '0;
        reset_link_state();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();

        settle();
        if (errors == 0)
            $display("tb_ps2_host_link_frame_engine: clean");
        else
            $display("tb_ps2_host_link_frame_engine: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ps2hl_pkg.sv
rtl/core/ps2_host_link_frame_engine.sv
bench/tb_ps2_host_link_frame_engine.sv
